FILE: hw/rtl/bgcd_pkg.sv
// shared widths and controller/datapath handshake types for the binary gcd unit
package bgcd_pkg;

   localparam int BGCD_WIDTH = 32;
   localparam int SHIFT_W    = $clog2(BGCD_WIDTH);

   typedef logic [BGCD_WIDTH-1:0] word_type;
   typedef logic [SHIFT_W-1:0]    shift_type;

   // commands from controller to datapath, at most one per cycle
   typedef struct packed {
      logic load;
      logic take_b;
      logic strip;
      logic shift_a;
      logic shift_b;
      logic step;
      logic finish;
   } bgcd_cmd_type;

   // flags from datapath back to controller
   typedef struct packed {
      logic a_zero;
      logic b_zero;
      logic a_odd;
      logic b_odd;
      logic a_eq_b;
   } bgcd_status_type;

endpackage

FILE: hw/rtl/bgcd_if.sv
// valid/ready channel interfaces for operand and result words
interface bgcd_req_if
   import bgcd_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type operand_a;
   word_type operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface bgcd_rsp_if
   import bgcd_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type gcd_value;

   modport source (output valid, output gcd_value, input ready);
   modport sink   (input valid, input gcd_value, output ready);
endinterface

FILE: hw/rtl/bgcd_dp.sv
// binary gcd datapath: operand registers, shared-twos count, result register
module bgcd_dp
   import bgcd_pkg::*;
(
   input  logic            clock,
   input  bgcd_cmd_type    cmd,
   input  word_type        operand_a,
   input  word_type        operand_b,
   output bgcd_status_type status,
   output word_type        gcd_value
);

   word_type  a_ff, a_in;
   word_type  b_ff, b_in;
   shift_type shared_ff, shared_in;
   word_type  result_ff, result_in;

   logic [BGCD_WIDTH:0] diff_ba;
   word_type            diff_ab;

   assign diff_ba = {1'b0, b_ff} - {1'b0, a_ff};
   assign diff_ab = a_ff - b_ff;

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      shared_in = shared_ff;
      result_in = result_ff;
      if (cmd.load) begin
         a_in      = operand_a;
         b_in      = operand_b;
         shared_in = '0;
      end
      if (cmd.take_b) begin
         a_in = b_ff;
      end
      if (cmd.strip) begin
         a_in      = a_ff >> 1;
         b_in      = b_ff >> 1;
         shared_in = shared_ff + 1'b1;
      end
      if (cmd.shift_a) begin
         a_in = a_ff >> 1;
      end
      if (cmd.shift_b) begin
         b_in = b_ff >> 1;
      end
      if (cmd.step) begin
         // borrow set means a > b: swap, then subtract
         if (diff_ba[BGCD_WIDTH]) begin
            a_in = b_ff;
            b_in = diff_ab;
         end else begin
            b_in = diff_ba[BGCD_WIDTH-1:0];
         end
      end
      if (cmd.finish) begin
         result_in = a_ff << shared_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      shared_ff <= shared_in;
      result_ff <= result_in;
   end

   assign status.a_zero = (a_ff == '0);
   assign status.b_zero = (b_ff == '0);
   assign status.a_odd  = a_ff[0];
   assign status.b_odd  = b_ff[0];
   assign status.a_eq_b = (a_ff == b_ff);
   assign gcd_value     = result_ff;

endmodule

FILE: hw/rtl/bgcd_ctrl.sv
// binary gcd controller: sequences load, strip, reduce and result handoff
module bgcd_ctrl
   import bgcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  bgcd_status_type status,
   output bgcd_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_STRIP  = 3'd2;
   localparam logic [2:0] ST_ODDA   = 3'd3;
   localparam logic [2:0] ST_LOOP   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.a_zero) begin
               cmd.take_b = 1'b1;
               state_in   = ST_FINISH;
            end else if (status.b_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (!status.a_odd && !status.b_odd) begin
               cmd.strip = 1'b1;
            end else begin
               state_in = ST_ODDA;
            end
         end
         ST_ODDA: begin
            if (!status.a_odd) begin
               cmd.shift_a = 1'b1;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (!status.b_odd) begin
               cmd.shift_b = 1'b1;
            end else begin
               cmd.step = 1'b1;
               // equal odd operands: difference goes to zero, a holds the gcd
               if (status.a_eq_b) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/binary_gcd_unit.sv
// binary gcd unit top: greatest common divisor of two words, stein's method
// the run time is data dependent: an operand of zero goes straight to the result,
// otherwise one shift or one compare-subtract per cycle until the operands are equal
// throughput is one word at a time; the next word is taken the cycle after the result registers
// the result waits in an output register, so a new word may enter while it is unclaimed
// synchronous active-high reset clears the controller state and the result valid flag
module binary_gcd_unit
   import bgcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bgcd_req_if.sink   req_chan,
   bgcd_rsp_if.source rsp_chan
);

   bgcd_cmd_type    cmd;
   bgcd_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   word_type        gcd_value;

   // sequencer: at most one command per cycle, holds the result handoff
   bgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // operand registers, subtractor, shifters and the result register
   bgcd_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .status    (status),
      .gcd_value (gcd_value)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.gcd_value = gcd_value;

`ifndef SYNTH
   // a word in hand blocks the next until its result is registered
   a_accept_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input taken while a word is still in work");

   // the subtract step only runs on two odd operands
   a_step_odd : assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (status.a_odd && status.b_odd))
      else $error("subtract step with an even operand");

   // controller never issues two commands at once
   a_cmd_single : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.take_b, cmd.strip, cmd.shift_a, cmd.shift_b, cmd.step,
                cmd.finish}))
      else $error("conflicting datapath commands");

   // a finished result is always offered in the next cycle
   a_finish_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_chan.valid)
      else $error("finished result not presented");
`endif

endmodule
